// ----- sv/section_timing_statistics_defines.svh -----
// assertion macros for the section timing statistics block
// used by the port checker; needs a clk and rst in scope
`ifndef SECTION_TIMING_STATISTICS_DEFINES_SVH
`define SECTION_TIMING_STATISTICS_DEFINES_SVH

// condition in a cycle implies a consequence in the same cycle
`define STS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sts port check failed");

// condition in a cycle implies a consequence in the next cycle
`define STS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sts port check failed");

`endif

// ----- sv/sts_pkg.sv -----
// types and constants shared by the section timing statistics block
// no dependencies
`timescale 1ns / 1ps

package sts_pkg;

  // number of profiling slots and the width of a slot table index
  localparam int SLOTS   = 8;
  localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // event codes
  localparam logic [2:0] FUNC_START     = 3'd0;
  localparam logic [2:0] FUNC_END       = 3'd1;
  localparam logic [2:0] FUNC_CLEAR     = 3'd2;
  localparam logic [2:0] FUNC_CLEAR_ALL = 3'd3;
  localparam logic [2:0] FUNC_QUERY     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLE     = 2'd0;
  localparam logic [1:0] REG_CYC_PER_US = 2'd1;

  localparam logic       ENABLE_RESET     = 1'b1;
  localparam logic [9:0] CYC_PER_US_RESET = 10'd168;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [31:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic        busy_section;
    logic [31:0] last_elapsed;
    logic [31:0] least_elapsed;
    logic [31:0] most_elapsed;
    logic [63:0] sum_elapsed;
    logic [31:0] section_count;
    logic [31:0] mean_cycles;
    logic [31:0] mean_us;
  } out_word_t;

  // statistics of one slot as read from the table
  typedef struct packed {
    logic        open;
    logic [31:0] last;
    logic [31:0] low;
    logic [31:0] high;
    logic [63:0] sum;
    logic [31:0] count;
  } slot_stats_t;

  // event command from the input channel to the slot table
  typedef struct packed {
    logic        valid;
    logic [2:0]  func;
    logic        ok;
    logic [31:0] timestamp;
  } slot_cmd_t;

endpackage

// ----- sv/sts_slot_table.sv -----
// per-slot timing state and its update on start, end and clear events
// depends on sts_pkg
`timescale 1ns / 1ps

module sts_slot_table (
  input  logic                        clk,
  input  logic                        rst,
  input  sts_pkg::slot_cmd_t          cmd,
  input  logic [sts_pkg::SLOT_IW-1:0] idx,
  output sts_pkg::slot_stats_t        stats
);
  import sts_pkg::*;

  logic [31:0] open_time  [SLOTS];
  logic        open_flag  [SLOTS];
  logic [31:0] last_time  [SLOTS];
  logic [31:0] low_time   [SLOTS];
  logic [31:0] high_time  [SLOTS];
  logic [63:0] sum_time   [SLOTS];
  logic [31:0] done_count [SLOTS];

  logic [31:0] elapsed;

  // read port at the addressed slot
  always_comb begin
    stats.open  = open_flag[idx];
    stats.last  = last_time[idx];
    stats.low   = low_time[idx];
    stats.high  = high_time[idx];
    stats.sum   = sum_time[idx];
    stats.count = done_count[idx];
  end

  // elapsed time wraps modulo 2^32
  assign elapsed = cmd.timestamp - open_time[idx];

  // event updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        open_time[s]  <= '0;
        open_flag[s]  <= 1'b0;
        last_time[s]  <= '0;
        low_time[s]   <= '1;
        high_time[s]  <= '0;
        sum_time[s]   <= '0;
        done_count[s] <= '0;
      end
    end else if (cmd.valid) begin
      case (cmd.func)
        FUNC_START: begin
          if (cmd.ok) begin
            open_time[idx] <= cmd.timestamp;
            open_flag[idx] <= 1'b1;
          end
        end
        FUNC_END: begin
          if (cmd.ok && open_flag[idx]) begin
            last_time[idx]  <= elapsed;
            sum_time[idx]   <= sum_time[idx] + {32'd0, elapsed};
            done_count[idx] <= done_count[idx] + 32'd1;
            if (elapsed < low_time[idx]) low_time[idx] <= elapsed;
            if (elapsed > high_time[idx]) high_time[idx] <= elapsed;
            open_flag[idx]  <= 1'b0;
          end
        end
        FUNC_CLEAR: begin
          if (cmd.ok) begin
            open_time[idx]  <= '0;
            open_flag[idx]  <= 1'b0;
            last_time[idx]  <= '0;
            low_time[idx]   <= '1;
            high_time[idx]  <= '0;
            sum_time[idx]   <= '0;
            done_count[idx] <= '0;
          end
        end
        FUNC_CLEAR_ALL: begin
          for (int s = 0; s < SLOTS; s++) begin
            open_time[s]  <= '0;
            open_flag[s]  <= 1'b0;
            last_time[s]  <= '0;
            low_time[s]   <= '1;
            high_time[s]  <= '0;
            sum_time[s]   <= '0;
            done_count[s] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/sts_divider.sv -----
// serial restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle
// depends on sts_pkg, which it imports; no other dependencies
`timescale 1ns / 1ps

module sts_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import sts_pkg::*;

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [6:0]  steps;
  logic        busy;

  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        ge;

  // one quotient bit per step; a zero divisor gives all ones
  assign rem_sh = {rem, quotient[63]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge     = !diff[33];

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done <= !start && busy && (steps == 7'd63);
      if (start) begin
        busy  <= 1'b1;
        steps <= 7'd0;
      end else if (busy) begin
        steps <= steps + 7'd1;
        if (steps == 7'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[31:0] : rem_sh[31:0];
      quotient <= {quotient[62:0], ge};
    end
  end

endmodule

// ----- sv/section_timing_statistics.sv -----
// top level of the section timing statistics block: sequencer, config, output word
// depends on sts_pkg, sts_slot_table, sts_divider
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+-------------------------
//  in       | into      | in_valid/in_stall  | in_word_t (event/query)
//  out      | out of    | out_valid/out_stall| out_word_t (query result)
//  cfg      | into      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// start, end and clear events update the slot table directly and do not themselves stall the input.
// a query on a valid slot with a nonzero count runs two 64-step passes of the shared
// serial divider (mean cycles, then mean microseconds); any other query skips them.
// reset is synchronous; it restores every slot and both registers at once.
// a finished result waits in the output register while events keep flowing;
// a later query holds at its end until that register is free.
`timescale 1ns / 1ps

module section_timing_statistics (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sts_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sts_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);
  import sts_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MEAN, ST_US, ST_DONE} state_t;

  state_t      state;
  logic        enable;
  logic [9:0]  cyc_per_us;

  logic        in_acc;
  logic        slot_ok;
  slot_cmd_t   cmd;
  slot_stats_t stats;

  slot_stats_t snap;
  logic        snap_ok;
  logic [31:0] mean_c;
  logic [31:0] mean_u;

  logic        div_go;
  logic [63:0] div_dvd;
  logic [31:0] div_dvs;
  logic        div_done;
  logic [63:0] div_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_ok   = enable && ({1'b0, in_data.slot} < 5'(SLOTS));

  // event command to the slot table
  always_comb begin
    cmd.valid     = in_acc && enable;
    cmd.func      = in_data.func;
    cmd.ok        = slot_ok;
    cmd.timestamp = in_data.timestamp;
  end

  sts_slot_table u_table (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .idx   (in_data.slot[SLOT_IW-1:0]),
    .stats (stats)
  );

  sts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= ENABLE_RESET;
      cyc_per_us <= CYC_PER_US_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:     enable     <= cfg_data[0];
        REG_CYC_PER_US: cyc_per_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // query sequencer and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      div_go    <= 1'b0;
    end else begin
      // a taken word leaves unless a new one is loaded in its place
      if (state != ST_DONE && out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          div_go <= in_acc && in_data.func == FUNC_QUERY && slot_ok &&
                    stats.count != 32'd0;
          if (in_acc && in_data.func == FUNC_QUERY) begin
            snap    <= stats;
            snap_ok <= slot_ok;
            mean_c  <= '0;
            mean_u  <= '0;
            if (slot_ok && stats.count != 32'd0) begin
              div_dvd <= stats.sum;
              div_dvs <= stats.count;
              state   <= ST_MEAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_MEAN: begin
          div_go <= div_done;
          if (div_done) begin
            mean_c  <= div_q[31:0];
            div_dvd <= {32'd0, div_q[31:0]};
            div_dvs <= {22'd0, cyc_per_us};
            state   <= ST_US;
          end
        end
        ST_US: begin
          div_go <= 1'b0;
          if (div_done) begin
            mean_u <= div_q[31:0];
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          div_go <= 1'b0;
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (snap_ok) begin
              out_data.status        <= 1'b0;
              out_data.busy_section  <= snap.open;
              out_data.last_elapsed  <= snap.last;
              out_data.least_elapsed <= snap.low;
              out_data.most_elapsed  <= snap.high;
              out_data.sum_elapsed   <= snap.sum;
              out_data.section_count <= snap.count;
              out_data.mean_cycles   <= mean_c;
              out_data.mean_us       <= mean_u;
            end else begin
              // error word carries only its status
              out_data.status        <= 1'b1;
              out_data.busy_section  <= 1'b0;
              out_data.last_elapsed  <= '0;
              out_data.least_elapsed <= '0;
              out_data.most_elapsed  <= '0;
              out_data.sum_elapsed   <= '0;
              out_data.section_count <= '0;
              out_data.mean_cycles   <= '0;
              out_data.mean_us       <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          div_go <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/sts_checker.sv -----
// port-level checks for the section timing statistics block, bound to the top
// depends on sts_pkg and section_timing_statistics_defines.svh
`timescale 1ns / 1ps
`include "section_timing_statistics_defines.svh"

module sts_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input sts_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input sts_pkg::out_word_t out_data
);
  import sts_pkg::*;

  // an error word shows a zero count, a zero mean in cycles and no open section
  `STS_ASSERT_NOW(a_err_word_empty, out_valid && out_data.status, out_data.section_count == 32'd0 && out_data.mean_cycles == 32'd0 && out_data.busy_section == 1'b0)

  // with no sections counted both means read zero
  `STS_ASSERT_NOW(a_zero_count_means, out_valid && out_data.section_count == 32'd0, out_data.mean_cycles == 32'd0 && out_data.mean_us == 32'd0)

  // once a section is counted the minimum does not exceed the maximum
  `STS_ASSERT_NOW(a_min_le_max, out_valid && !out_data.status && out_data.section_count != 32'd0, out_data.least_elapsed <= out_data.most_elapsed)

  // a held result word keeps its value
  `STS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind section_timing_statistics sts_checker u_sts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
